/* hw/rtl/baro_comp_pkg.sv */
// Shared types, register map and constants of the barometric compensation block.
package baro_comp_pkg;

    // Input item: raw sensor words
    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [18:0] raw_pressure;
    } t_in_item;

    // Result item: compensated values and fault flag
    typedef struct packed {
        logic signed [15:0] temperature_tenths;
        logic signed [31:0] pressure_pa;
        logic               divide_fault;
    } t_out_item;

    // Register map, word index = paddr[4:2]
    localparam int unsigned ADDR_W = 5;
    localparam logic [2:0] REG_AC1  = 3'd0;
    localparam logic [2:0] REG_AC2  = 3'd1;
    localparam logic [2:0] REG_AC3  = 3'd2;
    localparam logic [2:0] REG_AC4  = 3'd3;
    localparam logic [2:0] REG_AC56 = 3'd4;
    localparam logic [2:0] REG_B1B2 = 3'd5;
    localparam logic [2:0] REG_MCMD = 3'd6;
    localparam logic [2:0] REG_OSS  = 3'd7;

    // Factory calibration defaults
    localparam logic [15:0] RST_AC1  = 16'h0198;
    localparam logic [15:0] RST_AC2  = 16'hFFB8;
    localparam logic [15:0] RST_AC3  = 16'hC7D1;
    localparam logic [15:0] RST_AC4  = 16'h7FE5;
    localparam logic [31:0] RST_AC56 = 32'h7FF5_5A71;
    localparam logic [31:0] RST_B1B2 = 32'h182E_0004;
    localparam logic [31:0] RST_MCMD = 32'hDDF9_0B34;
    localparam logic [1:0]  RST_OSS  = 2'd1;

    // Algorithm constants
    localparam logic signed [28:0] B6_OFFSET = 29'sd4000;
    localparam logic [15:0]        B7_SCALE  = 16'd50000;
    localparam logic [31:0]        X3_BIAS   = 32'd32768;
    localparam logic signed [12:0] P_C1      = 13'sd3038;
    localparam logic signed [13:0] P_C2      = -14'sd7357;
    localparam logic signed [45:0] P_C3      = 46'sd3791;

    // Pipelined divider depths: one quotient bit per stage
    localparam int unsigned DIV1_STEPS = 27;
    localparam int unsigned DIV2_STEPS = 32;

endpackage

/* hw/rtl/baro_sensor_compensation.sv */
// Top level: pipelined temperature and pressure compensation datapath.
//
//  channel   direction  handshake                 payload
//  input     in         i_valid / o_stall         i_item (t_in_item)
//  output    out        o_valid / i_stall         o_item (t_out_item)
//  config    in         psel/penable/pwrite/...   pwdata / prdata, 32 bits
//
// One item enters every cycle while the output is not stalled; the two
// bit-per-stage dividers (27 and 32 stages) and twelve arithmetic stages form the pipeline.
// Reset is synchronous, active low, clears valid bits and loads factory calibration defaults.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
module baro_sensor_compensation import baro_comp_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  t_in_item            i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output t_out_item           o_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    typedef struct packed {
        logic signed [17:0] x1;
        logic [18:0]        up;
        logic               neg;
        logic               flt;
    } t_d1_side;

    typedef struct packed {
        logic signed [15:0] t;
        logic               big;
        logic               flt;
    } t_d2_side;

    // Configuration registers
    logic signed [15:0] r_ac1, r_ac2, r_ac3;
    logic [15:0]        r_ac4;
    logic [31:0]        r_ac56, r_b1b2, r_mcmd;
    logic [1:0]         r_oss;

    logic               w_en;
    logic               w_wr;

    // Stage 1
    logic signed [16:0] c_diff, c_ac5;
    logic signed [33:0] c_prod1;
    logic               r1_vld;
    logic signed [17:0] r1_x1;
    logic [18:0]        r1_up;

    // Stage 2 / divider 1
    logic signed [18:0] c_den;
    logic signed [26:0] c_num;
    logic               r_d1_vld  [0:DIV1_STEPS];
    logic [26:0]        r_d1_num  [0:DIV1_STEPS];
    logic [18:0]        r_d1_rem  [0:DIV1_STEPS];
    logic [18:0]        r_d1_den  [0:DIV1_STEPS];
    t_d1_side           r_d1_side [0:DIV1_STEPS];

    // Stage 3
    logic [26:0]        c_q1;
    logic signed [27:0] c_x2, c_b5;
    logic signed [28:0] c_tb;
    logic signed [24:0] c_tr;
    logic signed [15:0] c_t;
    logic               r3_vld, r3_flt;
    logic signed [28:0] r3_b6;
    logic signed [15:0] r3_t;
    logic [18:0]        r3_up;

    // Stage 4
    logic signed [57:0] c_sqp;
    logic signed [44:0] c_a2p, c_a3p;
    logic               r4_vld, r4_flt;
    logic signed [45:0] r4_sq;
    logic signed [33:0] r4_x2a;
    logic signed [31:0] r4_x1b;
    logic signed [15:0] r4_t;
    logic [18:0]        r4_up;

    // Stage 5
    logic signed [61:0] c_b2p, c_b1p;
    logic               r5_vld, r5_flt;
    logic signed [50:0] r5_x1a;
    logic signed [45:0] r5_x2b;
    logic signed [33:0] r5_x2a;
    logic signed [31:0] r5_x1b;
    logic signed [15:0] r5_t;
    logic [18:0]        r5_up;

    // Stage 6
    logic signed [52:0] c_x3a;
    logic signed [47:0] c_x3b;
    logic               r6_vld, r6_flt;
    logic signed [52:0] r6_sa;
    logic [31:0]        r6_u;
    logic signed [15:0] r6_t;
    logic [18:0]        r6_up;

    // Stage 7
    logic signed [56:0] c_sa, c_sh, c_v, c_va;
    logic [47:0]        c_b4p;
    logic               r7_vld, r7_flt;
    logic [31:0]        r7_b3, r7_b4;
    logic signed [15:0] r7_t;
    logic [18:0]        r7_up;

    // Stage 8
    logic [31:0]        c_d32;
    logic [15:0]        c_scale;
    logic [47:0]        c_b7p;
    logic               r8_vld, r8_flt;
    logic [31:0]        r8_b7, r8_b4;
    logic signed [15:0] r8_t;

    // Divider 2
    logic               r_d2_vld  [0:DIV2_STEPS];
    logic [31:0]        r_d2_num  [0:DIV2_STEPS];
    logic [31:0]        r_d2_rem  [0:DIV2_STEPS];
    logic [31:0]        r_d2_den  [0:DIV2_STEPS];
    t_d2_side           r_d2_side [0:DIV2_STEPS];

    // Stage 10
    logic [31:0]        c_q2, c_p;
    logic signed [23:0] c_x1p;
    logic signed [47:0] c_sq2;
    logic signed [45:0] c_x2p;
    logic               r10_vld, r10_flt;
    logic signed [31:0] r10_pp;
    logic signed [47:0] r10_sq2;
    logic signed [29:0] r10_x2c;
    logic signed [15:0] r10_t;

    // Stage 11
    logic signed [60:0] c_x1cp;
    logic               r11_vld, r11_flt;
    logic signed [31:0] r11_pp;
    logic signed [44:0] r11_x1c;
    logic signed [29:0] r11_x2c;
    logic signed [15:0] r11_t;

    // Output stage
    logic signed [45:0] c_s;
    logic [31:0]        c_fin;
    logic               r_out_vld;
    t_out_item          r_out;

    // Advance the whole pipeline unless the held result is stalled
    assign w_en    = !(r_out_vld && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_out_vld;
    assign o_item  = r_out;

    // Configuration port
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac1  <= RST_AC1;
            r_ac2  <= RST_AC2;
            r_ac3  <= RST_AC3;
            r_ac4  <= RST_AC4;
            r_ac56 <= RST_AC56;
            r_b1b2 <= RST_B1B2;
            r_mcmd <= RST_MCMD;
            r_oss  <= RST_OSS;
        end else if (w_wr) begin
            case (paddr[4:2])
                REG_AC1:  r_ac1  <= pwdata[15:0];
                REG_AC2:  r_ac2  <= pwdata[15:0];
                REG_AC3:  r_ac3  <= pwdata[15:0];
                REG_AC4:  r_ac4  <= pwdata[15:0];
                REG_AC56: r_ac56 <= pwdata;
                REG_B1B2: r_b1b2 <= pwdata;
                REG_MCMD: r_mcmd <= pwdata;
                REG_OSS:  r_oss  <= pwdata[1:0];
                default:  ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (paddr[4:2])
            REG_AC1:  prdata = {16'h0000, r_ac1};
            REG_AC2:  prdata = {16'h0000, r_ac2};
            REG_AC3:  prdata = {16'h0000, r_ac3};
            REG_AC4:  prdata = {16'h0000, r_ac4};
            REG_AC56: prdata = r_ac56;
            REG_B1B2: prdata = r_b1b2;
            REG_MCMD: prdata = r_mcmd;
            REG_OSS:  prdata = {30'd0, r_oss};
            default:  prdata = 32'd0;
        endcase
    end

    // Stage 1: X1 = ((UT - AC6) * AC5) >> 15
    assign c_diff  = $signed({1'b0, i_item.raw_temperature}) - $signed({1'b0, r_ac56[15:0]});
    assign c_ac5   = $signed({1'b0, r_ac56[31:16]});
    assign c_prod1 = c_diff * c_ac5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_x1 <= c_prod1[32:15];
            r1_up <= i_item.raw_pressure;
        end
    end

    // Stage 2: split MC*2048 / (X1 + MD) into sign and magnitudes
    assign c_den = r1_x1 + $signed(r_mcmd[15:0]);
    assign c_num = $signed({r_mcmd[31:16], 11'd0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_d1_vld[0] <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d1_num[0]      <= c_num[26] ? 27'(-c_num) : 27'(c_num);
            r_d1_rem[0]      <= '0;
            r_d1_den[0]      <= c_den[18] ? 19'(-c_den) : 19'(c_den);
            r_d1_side[0].x1  <= r1_x1;
            r_d1_side[0].up  <= r1_up;
            r_d1_side[0].neg <= c_num[26] ^ c_den[18];
            r_d1_side[0].flt <= (c_den == '0);
        end
    end

    // Divider 1: restoring, one quotient bit per stage
    for (genvar k = 0; k < DIV1_STEPS; k++) begin : g_div1
        logic [19:0] w_trial;
        logic        w_ge;

        assign w_trial = {r_d1_rem[k], r_d1_num[k][26]};
        assign w_ge    = (w_trial >= {1'b0, r_d1_den[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d1_vld[k+1] <= 1'b0;
            end else if (w_en) begin
                r_d1_vld[k+1] <= r_d1_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_d1_rem[k+1]  <= w_ge ? 19'(w_trial - {1'b0, r_d1_den[k]}) : w_trial[18:0];
                r_d1_num[k+1]  <= {r_d1_num[k][25:0], w_ge};
                r_d1_den[k+1]  <= r_d1_den[k];
                r_d1_side[k+1] <= r_d1_side[k];
            end
        end
    end

    // Stage 3: B5, saturated temperature, B6
    assign c_q1 = r_d1_num[DIV1_STEPS];
    assign c_x2 = r_d1_side[DIV1_STEPS].neg ? -$signed({1'b0, c_q1}) : $signed({1'b0, c_q1});
    assign c_b5 = r_d1_side[DIV1_STEPS].x1 + c_x2;
    assign c_tb = c_b5 + 29'sd8;
    assign c_tr = c_tb[28:4];

    always_comb begin
        if ((&c_tr[24:15]) || !(|c_tr[24:15])) begin
            c_t = c_tr[15:0];
        end else begin
            c_t = c_tr[24] ? 16'sh8000 : 16'sh7FFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_en) begin
            r3_vld <= r_d1_vld[DIV1_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_b6  <= c_b5 - B6_OFFSET;
            r3_t   <= c_t;
            r3_up  <= r_d1_side[DIV1_STEPS].up;
            r3_flt <= r_d1_side[DIV1_STEPS].flt;
        end
    end

    // Stage 4: B6 squared, AC2*B6, AC3*B6
    assign c_sqp = r3_b6 * r3_b6;
    assign c_a2p = r_ac2 * r3_b6;
    assign c_a3p = r_ac3 * r3_b6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (w_en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_sq  <= c_sqp[57:12];
            r4_x2a <= c_a2p[44:11];
            r4_x1b <= c_a3p[44:13];
            r4_t   <= r3_t;
            r4_up  <= r3_up;
            r4_flt <= r3_flt;
        end
    end

    // Stage 5: B2 and B1 terms
    assign c_b2p = $signed(r_b1b2[15:0]) * r4_sq;
    assign c_b1p = $signed(r_b1b2[31:16]) * r4_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (w_en) begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_x1a <= c_b2p[61:11];
            r5_x2b <= c_b1p[61:16];
            r5_x2a <= r4_x2a;
            r5_x1b <= r4_x1b;
            r5_t   <= r4_t;
            r5_up  <= r4_up;
            r5_flt <= r4_flt;
        end
    end

    // Stage 6: sums for B3 and for the B4 operand
    assign c_x3a = r5_x1a + r5_x2a + $signed({r_ac1, 2'b00});
    assign c_x3b = r5_x1b + r5_x2b + 48'sd2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (w_en) begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_sa  <= c_x3a;
            r6_u   <= c_x3b[33:2] + X3_BIAS;
            r6_t   <= r5_t;
            r6_up  <= r5_up;
            r6_flt <= r5_flt;
        end
    end

    // Stage 7: B3 with truncating divide by four, B4
    assign c_sa  = r6_sa;
    assign c_sh  = c_sa <<< r_oss;
    assign c_v   = c_sh + 57'sd2;
    assign c_va  = c_v + (c_v[56] ? 57'sd3 : 57'sd0);
    assign c_b4p = r_ac4 * r6_u;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (w_en) begin
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_b3  <= c_va[33:2];
            r7_b4  <= c_b4p[46:15];
            r7_t   <= r6_t;
            r7_up  <= r6_up;
            r7_flt <= r6_flt;
        end
    end

    // Stage 8: B7
    assign c_d32   = {13'd0, r7_up} - r7_b3;
    assign c_scale = B7_SCALE >> r_oss;
    assign c_b7p   = c_d32 * c_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else if (w_en) begin
            r8_vld <= r7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_b7  <= c_b7p[31:0];
            r8_b4  <= r7_b4;
            r8_t   <= r7_t;
            r8_flt <= r7_flt || (r7_b4 == '0);
        end
    end

    // Stage 9: load divider 2, doubling B7 first when it fits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d2_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_d2_vld[0] <= r8_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d2_num[0]      <= r8_b7[31] ? r8_b7 : {r8_b7[30:0], 1'b0};
            r_d2_rem[0]      <= '0;
            r_d2_den[0]      <= r8_b4;
            r_d2_side[0].t   <= r8_t;
            r_d2_side[0].big <= r8_b7[31];
            r_d2_side[0].flt <= r8_flt;
        end
    end

    // Divider 2: restoring, one quotient bit per stage
    for (genvar k = 0; k < DIV2_STEPS; k++) begin : g_div2
        logic [32:0] w_trial;
        logic        w_ge;

        assign w_trial = {r_d2_rem[k], r_d2_num[k][31]};
        assign w_ge    = (w_trial >= {1'b0, r_d2_den[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d2_vld[k+1] <= 1'b0;
            end else if (w_en) begin
                r_d2_vld[k+1] <= r_d2_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_d2_rem[k+1]  <= w_ge ? 32'(w_trial - {1'b0, r_d2_den[k]}) : w_trial[31:0];
                r_d2_num[k+1]  <= {r_d2_num[k][30:0], w_ge};
                r_d2_den[k+1]  <= r_d2_den[k];
                r_d2_side[k+1] <= r_d2_side[k];
            end
        end
    end

    // Stage 10: p, (p >> 8) squared, -7357 * p
    assign c_q2  = r_d2_num[DIV2_STEPS];
    assign c_p   = r_d2_side[DIV2_STEPS].big ? {c_q2[30:0], 1'b0} : c_q2;
    assign c_x1p = $signed(c_p[31:8]);
    assign c_sq2 = c_x1p * c_x1p;
    assign c_x2p = P_C2 * $signed(c_p);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_vld <= 1'b0;
        end else if (w_en) begin
            r10_vld <= r_d2_vld[DIV2_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r10_pp  <= $signed(c_p);
            r10_sq2 <= c_sq2;
            r10_x2c <= c_x2p[45:16];
            r10_t   <= r_d2_side[DIV2_STEPS].t;
            r10_flt <= r_d2_side[DIV2_STEPS].flt;
        end
    end

    // Stage 11: 3038 term
    assign c_x1cp = r10_sq2 * P_C1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r11_vld <= 1'b0;
        end else if (w_en) begin
            r11_vld <= r10_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r11_pp  <= r10_pp;
            r11_x1c <= c_x1cp[60:16];
            r11_x2c <= r10_x2c;
            r11_t   <= r10_t;
            r11_flt <= r10_flt;
        end
    end

    // Output stage: final correction, zero both results on a fault
    assign c_s   = r11_x1c + r11_x2c + P_C3;
    assign c_fin = r11_pp + c_s[35:4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r11_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.temperature_tenths <= r11_flt ? 16'sd0 : r11_t;
            r_out.pressure_pa        <= r11_flt ? 32'sd0 : $signed(c_fin);
            r_out.divide_fault       <= r11_flt;
        end
    end

endmodule

/* hw/rtl/baro_comp_chk.sv */
// Port-level checker for the barometric compensation block, with its bind.
module baro_comp_chk import baro_comp_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input t_out_item         o_item,
    input logic              psel,
    input logic              pready
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("stalled result changed");

    // Stall the input only behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a stalled result");

    // Zero both results on a divide fault
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.divide_fault |->
            o_item.temperature_tenths == 16'sd0 && o_item.pressure_pa == 32'sd0)
        else $error("faulted item carries non-zero results");

    // Answer every register access at once
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel |-> pready)
        else $error("register access not ready");

endmodule

bind baro_sensor_compensation baro_comp_chk u_baro_comp_chk (.*);

/* dv/tb_baro_sensor_compensation.sv */
// Self-checking testbench for the barometric compensation block.
module tb_baro_sensor_compensation;
    import baro_comp_pkg::*;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    t_in_item          i_item;
    logic              o_valid;
    logic              i_stall;
    t_out_item         o_item;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    localparam int LATENCY = 71;
    localparam longint CYCLE_LIMIT = 3000000;

    // Local copy of the calibration registers
    logic [15:0] cal_ac1, cal_ac2, cal_ac3, cal_ac4;
    logic [31:0] cal_ac56, cal_b1b2, cal_mcmd;
    logic [1:0]  cal_oss;

    t_out_item expected_q[$];
    int        error_count;
    longint    cycle_count = 0;
    bit        drive_gaps;

    baro_sensor_compensation u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Cycle counter and timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // floor division by 2^n
    function automatic longint floor_shift(longint v, int n);
        return v >>> n;
    endfunction

    // Compute the compensated temperature and pressure for one raw pair
    function automatic t_out_item compensate(t_in_item raw);
        t_out_item res;
        longint ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md, ut;
        longint x1, x2, x3, b5, b6, b3, t, den, sq, pp, fin;
        longint unsigned up, b4, b7, p;
        int os;
        ac1 = longint'($signed(cal_ac1));
        ac2 = longint'($signed(cal_ac2));
        ac3 = longint'($signed(cal_ac3));
        ac5 = longint'(cal_ac56[31:16]);
        ac6 = longint'(cal_ac56[15:0]);
        b1  = longint'($signed(cal_b1b2[31:16]));
        b2  = longint'($signed(cal_b1b2[15:0]));
        mc  = longint'($signed(cal_mcmd[31:16]));
        md  = longint'($signed(cal_mcmd[15:0]));
        os  = cal_oss;
        ut  = longint'(raw.raw_temperature);
        up  = 64'(raw.raw_pressure);
        res = '{temperature_tenths: '0, pressure_pa: '0, divide_fault: 1'b1};

        // temperature
        x1  = floor_shift((ut - ac6) * ac5, 15);
        den = x1 + md;
        if (den == 0) return res;
        x2 = (mc * 2048) / den;
        b5 = x1 + x2;
        t  = floor_shift(b5 + 8, 4);
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;

        // pressure
        b6 = b5 - 4000;
        sq = floor_shift(b6 * b6, 12);
        x1 = floor_shift(b2 * sq, 11);
        x2 = floor_shift(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = ((ac1 * 4 + x3) * (longint'(1) << os) + 2) / 4;
        x1 = floor_shift(ac3 * b6, 13);
        x2 = floor_shift(b1 * sq, 16);
        x3 = floor_shift(x1 + x2 + 2, 2);
        b4 = (64'(cal_ac4) * ((longint'(x3) + 32768) & 64'hFFFF_FFFF)) >> 15;
        b4 &= 64'hFFFF_FFFF;
        if (b4 == 0) return res;
        b7 = (((up - longint'(b3)) & 64'hFFFF_FFFF) * (64'd50000 >> os)) & 64'hFFFF_FFFF;
        if (b7 < 64'h8000_0000) p = ((b7 * 2) & 64'hFFFF_FFFF) / b4;
        else                    p = ((b7 / b4) * 2) & 64'hFFFF_FFFF;
        pp  = longint'($signed(p[31:0]));
        x1  = floor_shift(pp, 8);
        x1  = x1 * x1;
        x1  = floor_shift(x1 * 3038, 16);
        x2  = floor_shift(-7357 * pp, 16);
        fin = pp + floor_shift(x1 + x2 + 3791, 4);
        res.temperature_tenths = t[15:0];
        res.pressure_pa        = fin[31:0];
        res.divide_fault       = 1'b0;
        return res;
    endfunction

    // Random gap length: mostly short, sometimes long
    function automatic int gap_len();
        if ($urandom_range(0, 99) < 60) return 0;
        if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Write one calibration register and mirror it locally
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_AC1:  cal_ac1  = value[15:0];
            REG_AC2:  cal_ac2  = value[15:0];
            REG_AC3:  cal_ac3  = value[15:0];
            REG_AC4:  cal_ac4  = value[15:0];
            REG_AC56: cal_ac56 = value;
            REG_B1B2: cal_b1b2 = value;
            REG_MCMD: cal_mcmd = value;
            default:  cal_oss  = value[1:0];
        endcase
    endtask

    // Send one item; queue its prediction, or the typed-in value if given.
    // Valid stays high on return so that items can follow back to back.
    task automatic send_raw(t_in_item raw, bit has_known, t_out_item known);
        int g;
        if (drive_gaps) begin
            g = gap_len();
            if (g > 0) begin
                i_valid <= 1'b0;
                repeat (g) @(negedge i_clk);
            end
        end
        i_item  <= raw;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        expected_q.push_back(has_known ? known : compensate(raw));
        @(negedge i_clk);
    endtask

    // Drop valid, wait until all results are in, then let the pipeline drain
    task automatic drain();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    // Check results against the oldest expectation
    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result %p", $time, o_item);
                error_count++;
            end else begin
                exp_item = expected_q.pop_front();
                if (o_item.temperature_tenths !== exp_item.temperature_tenths) begin
                    $display("%0t: temperature exp %0d got %0d", $time,
                             exp_item.temperature_tenths, o_item.temperature_tenths);
                    error_count++;
                end
                if (o_item.pressure_pa !== exp_item.pressure_pa) begin
                    $display("%0t: pressure exp %0d got %0d", $time,
                             exp_item.pressure_pa, o_item.pressure_pa);
                    error_count++;
                end
                if (o_item.divide_fault !== exp_item.divide_fault) begin
                    $display("%0t: fault exp %0b got %0b", $time,
                             exp_item.divide_fault, o_item.divide_fault);
                    error_count++;
                end
            end
        end
    end

    // Receiver stall pattern
    initial begin
        int g;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 99) < 20) begin
                g = gap_len();
                if (g > 0) begin
                    i_stall <= 1'b1;
                    repeat (g) @(negedge i_clk);
                    i_stall <= 1'b0;
                end
            end else if ($urandom_range(0, 99) < 3) begin
                // stretch with no stalls
                repeat ($urandom_range(50, 200)) @(negedge i_clk);
            end
        end
    end

    typedef struct {
        logic [15:0] ut;
        logic [18:0] up;
        bit          known;
        t_out_item   res;
    } t_stim_row;

    // Directed rows at reset calibration: extremes and typical values
    t_stim_row dir_rows[] = '{
        '{16'd27898, 19'd23843, 1'b0, '0},
        '{16'd0,     19'd0,     1'b0, '0},
        '{16'hFFFF,  19'h7FFFF, 1'b0, '0},
        '{16'd0,     19'h7FFFF, 1'b0, '0},
        '{16'hFFFF,  19'd0,     1'b0, '0},
        '{16'hAAAA,  19'h2AAAA, 1'b0, '0},
        '{16'h5555,  19'h55555, 1'b0, '0},
        '{16'd23153, 19'd40000, 1'b0, '0}
    };

    initial begin
        t_in_item  raw;
        t_out_item zero_fault;
        int        n;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item  = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        error_count = 0;
        drive_gaps  = 1'b0;
        cal_ac1 = RST_AC1; cal_ac2 = RST_AC2; cal_ac3 = RST_AC3; cal_ac4 = RST_AC4;
        cal_ac56 = RST_AC56; cal_b1b2 = RST_B1B2; cal_mcmd = RST_MCMD; cal_oss = RST_OSS;
        zero_fault = '{temperature_tenths: '0, pressure_pa: '0, divide_fault: 1'b1};
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset calibration
        foreach (dir_rows[k]) begin
            raw.raw_temperature = dir_rows[k].ut;
            raw.raw_pressure    = dir_rows[k].up;
            send_raw(raw, dir_rows[k].known, dir_rows[k].res);
        end
        // Oversampling extremes
        for (int os = 0; os < 4; os++) begin
            drain();
            write_reg(REG_OSS, 32'(os));
            raw = '{raw_temperature: 16'd27898, raw_pressure: 19'h7FFFF};
            send_raw(raw, 1'b0, '0);
            raw = '{raw_temperature: 16'd27898, raw_pressure: 19'd0};
            send_raw(raw, 1'b0, '0);
        end
        // Zero temperature divisor: AC5 = 0 gives X1 = 0, MD = 0
        drain();
        write_reg(REG_AC56, 32'h0000_1234);
        write_reg(REG_MCMD, 32'hDDF9_0000);
        raw = '{raw_temperature: 16'd1000, raw_pressure: 19'd1234};
        send_raw(raw, 1'b1, zero_fault);
        // Zero pressure divisor: AC4 = 0
        drain();
        write_reg(REG_MCMD, RST_MCMD);
        write_reg(REG_AC56, RST_AC56);
        write_reg(REG_AC4, 32'd0);
        send_raw(raw, 1'b1, zero_fault);
        // Temperature saturation with extreme MC and small divisor
        drain();
        write_reg(REG_AC4, RST_AC4);
        write_reg(REG_AC56, 32'h0001_0000);
        write_reg(REG_MCMD, 32'h7FFF_0001);
        send_raw('{raw_temperature: 16'd0, raw_pressure: 19'd0}, 1'b0, '0);
        drain();
        write_reg(REG_MCMD, 32'h8000_0001);
        send_raw('{raw_temperature: 16'd0, raw_pressure: 19'h7FFFF}, 1'b0, '0);
        // Remaining extremes of the calibration words
        drain();
        write_reg(REG_AC1, 32'h8000);
        write_reg(REG_AC2, 32'h7FFF);
        write_reg(REG_AC3, 32'h8000);
        write_reg(REG_B1B2, 32'h7FFF_8000);
        write_reg(REG_AC56, 32'hFFFF_FFFF);
        write_reg(REG_MCMD, 32'h8000_7FFF);
        send_raw('{raw_temperature: 16'hFFFF, raw_pressure: 19'h7FFFF}, 1'b0, '0);
        send_raw('{raw_temperature: 16'd0, raw_pressure: 19'd0}, 1'b0, '0);

        // Random phases with varied calibration
        drive_gaps = 1'b1;
        for (int ph = 0; ph < 10; ph++) begin
            drain();
            if (ph == 0 || ph == 9) begin
                write_reg(REG_AC1, RST_AC1);   write_reg(REG_AC2, RST_AC2);
                write_reg(REG_AC3, RST_AC3);   write_reg(REG_AC4, RST_AC4);
                write_reg(REG_AC56, RST_AC56); write_reg(REG_B1B2, RST_B1B2);
                write_reg(REG_MCMD, RST_MCMD);
            end else if (ph < 6) begin
                // near-factory calibration keeps the results realistic
                write_reg(REG_AC1, 32'($urandom_range(0, 16000)));
                write_reg(REG_AC2, 32'(16'(-$urandom_range(0, 2000))));
                write_reg(REG_AC3, 32'(16'(-$urandom_range(10000, 20000))));
                write_reg(REG_AC4, 32'($urandom_range(20000, 40000)));
                write_reg(REG_AC56, {16'($urandom_range(20000, 32767)),
                                     16'($urandom_range(15000, 25000))});
                write_reg(REG_B1B2, {16'($urandom_range(5000, 7000)),
                                     16'($urandom_range(0, 100))});
                write_reg(REG_MCMD, {16'(-$urandom_range(8000, 12000)),
                                     16'($urandom_range(2000, 3500))});
            end else begin
                write_reg(REG_AC1, $urandom());  write_reg(REG_AC2, $urandom());
                write_reg(REG_AC3, $urandom());  write_reg(REG_AC4, $urandom());
                write_reg(REG_AC56, $urandom()); write_reg(REG_B1B2, $urandom());
                write_reg(REG_MCMD, $urandom());
            end
            write_reg(REG_OSS, 32'(ph % 4));
            n = 150;
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(0, 3) != 0) begin
                    raw.raw_temperature = 16'($urandom_range(15000, 40000));
                    raw.raw_pressure    = 19'($urandom_range(5000, 200000));
                end else begin
                    raw.raw_temperature = 16'($urandom());
                    raw.raw_pressure    = 19'($urandom());
                end
                send_raw(raw, 1'b0, '0);
                // hold off the sender until every result is back
                if (k == 75 && ph == 2) begin
                    i_valid <= 1'b0;
                    while (expected_q.size() != 0) @(posedge i_clk);
                end
            end
        end

        drain();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
